[hdl/ple_pkg.sv]
package ple_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Request modes
    localparam logic [2:0] MODE_INS_FRONT = 3'd0;
    localparam logic [2:0] MODE_INS_BACK  = 3'd1;
    localparam logic [2:0] MODE_DEL_FRONT = 3'd2;
    localparam logic [2:0] MODE_DEL_BACK  = 3'd3;
    localparam logic [2:0] MODE_INS_AT    = 3'd4;
    localparam logic [2:0] MODE_DEL_AT    = 3'd5;
    localparam logic [2:0] MODE_DUMP      = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // Datapath operations
    localparam logic [1:0] OP_NOP = 2'd0;
    localparam logic [1:0] OP_INS = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;
    localparam logic [1:0] OP_ROT = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] value;
        logic [4:0]  position;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_res;
        logic [4:0]  count;
        logic        last;
    } t_res;

    // Controller to datapath
    typedef struct packed {
        logic       emit;
        logic [1:0] op;
        logic [1:0] status;
        logic       last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } t_stat;

endpackage

[hdl/ple_ctrl.sv]
module ple_ctrl import ple_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int IW = $clog2(CAPACITY)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [2:0]    i_mode,
    input  logic [4:0]    i_position,
    input  t_stat         i_stat,
    input  logic [CW-1:0] i_count,
    output t_cmd          o_cmd,
    output logic [IW-1:0] o_idx
);

    localparam int PW = ((CW > 5) ? CW : 5) + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic          r_state, n_state;
    logic [CW-1:0] r_left,  n_left;

    logic          w_accept;
    logic [PW-1:0] w_pos;
    logic [PW-1:0] w_cnt;

    assign busy     = (r_state == S_DUMP);
    assign w_accept = start && !busy;
    assign w_pos    = PW'(i_position);
    assign w_cnt    = PW'(i_count);

    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        o_cmd.emit  = 1'b0;
        o_cmd.op    = OP_NOP;
        o_cmd.status = ST_OK;
        o_cmd.last  = 1'b1;
        o_idx       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.emit = 1'b1;
                    case (i_mode) inside
                        MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
                            if (i_stat.full) begin
                                o_cmd.status = ST_FULL;
                            end else if (i_mode == MODE_INS_FRONT) begin
                                o_cmd.op = OP_INS;
                            end else if (i_mode == MODE_INS_BACK) begin
                                o_cmd.op = OP_INS;
                                o_idx    = IW'(i_count);
                            end else if (w_pos == '0 || w_pos > w_cnt + PW'(1)) begin
                                o_cmd.status = ST_BADPOS;
                            end else begin
                                o_cmd.op = OP_INS;
                                o_idx    = IW'(w_pos - PW'(1));
                            end
                        end
                        MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
                            if (i_stat.empty) begin
                                o_cmd.status = ST_EMPTY;
                            end else if (i_mode == MODE_DEL_FRONT) begin
                                o_cmd.op = OP_DEL;
                            end else if (i_mode == MODE_DEL_BACK) begin
                                o_cmd.op = OP_DEL;
                                o_idx    = IW'(w_cnt - PW'(1));
                            end else if (w_pos == '0 || w_pos > w_cnt) begin
                                o_cmd.status = ST_BADPOS;
                            end else begin
                                o_cmd.op = OP_DEL;
                                o_idx    = IW'(w_pos - PW'(1));
                            end
                        end
                        MODE_DUMP: begin
                            if (i_stat.empty) begin
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                // emit the front word now, rotate the rest out
                                o_cmd.op   = OP_ROT;
                                o_cmd.last = (i_count == CW'(1));
                                n_left     = i_count - CW'(1);
                                if (i_count != CW'(1)) begin
                                    n_state = S_DUMP;
                                end
                            end
                        end
                        default: begin
                            o_cmd.status = ST_OK;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                o_cmd.emit = 1'b1;
                o_cmd.op   = OP_ROT;
                o_cmd.last = (r_left == CW'(1));
                n_left     = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

endmodule

[hdl/ple_dpath.sv]
module ple_dpath import ple_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int IW = $clog2(CAPACITY)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [IW-1:0] i_idx,
    input  logic [31:0]   i_value,
    output t_stat         o_stat,
    output logic [CW-1:0] o_count,
    output logic          o_valid,
    output t_res          o_res
);

    logic [DATA_WIDTH-1:0] r_cell [CAPACITY];
    logic [DATA_WIDTH-1:0] n_cell [CAPACITY];
    logic [CW-1:0]         r_count, n_count;
    logic                  r_valid;
    t_res                  r_res, n_res;
    logic [DATA_WIDTH-1:0] w_word;

    assign w_word       = DATA_WIDTH'(i_value);
    assign o_count      = r_count;
    assign o_stat.full  = (r_count >= CW'(CAPACITY));
    assign o_stat.empty = (r_count == '0);
    assign o_valid      = r_valid;
    assign o_res        = r_res;

    // Whole-row shift: each cell keeps its word, picks its neighbor or takes the new word
    always_comb begin
        n_count = r_count;
        for (int i = 0; i < CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
        end
        case (i_cmd.op)
            OP_INS: begin
                n_count = r_count + CW'(1);
                for (int i = 0; i < CAPACITY; i++) begin
                    if (i == int'(i_idx)) begin
                        n_cell[i] = w_word;
                    end else if (i > int'(i_idx)) begin
                        n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                    end
                end
            end
            OP_DEL: begin
                n_count = r_count - CW'(1);
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    if (i >= int'(i_idx)) begin
                        n_cell[i] = r_cell[i + 1];
                    end
                end
            end
            OP_ROT: begin
                // rotate the occupied cells left; after count steps the row is back
                for (int i = 0; i < CAPACITY; i++) begin
                    if (i + 1 < int'(r_count)) begin
                        n_cell[i] = r_cell[(i + 1 < CAPACITY) ? i + 1 : i];
                    end else if (i + 1 == int'(r_count)) begin
                        n_cell[i] = r_cell[0];
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_comb begin
        n_res.status    = i_cmd.status;
        n_res.value_res = (i_cmd.op == OP_ROT) ? 32'(r_cell[0]) : 32'd0;
        n_res.count     = 5'(n_count);
        n_res.last      = i_cmd.last;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_cell[i] <= n_cell[i];
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= i_cmd.emit;
        end
    end

endmodule

[hdl/positional_list_engine_top.sv]
// Positional list engine: a bounded ordered list of data words.
//
// Request channel: drive i_req (mode, value, position) and raise start; the
// request transfers at the rising edge where start is high and busy is low.
// Result channel: o_res is valid for exactly one cycle while o_valid is high.
// The receiver cannot stall; every result must be taken as it appears.
//
// The result is registered at the transfer edge and sits on o_res for the
// cycle that follows, to be taken at the edge ending it.
// Inserts, deletes and refused requests give one result each;
// busy stays low, so a new request may transfer in the very next cycle.
// A dump of N stored words gives N results on consecutive cycles and holds
// busy high while the rest are rotated out; the occupied cells rotate one
// place per cycle past the front cell, so N is set by that rotation.
// An empty dump gives a single result with status empty.
//
// Reset (synchronous, active low) empties the list and drops any pending
// result; the stored words themselves are not cleared.
module positional_list_engine_top import ple_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_res o_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [IW-1:0] w_idx;
    logic [CW-1:0] w_count;

    // Controller: decode the request, check bounds, sequence the dump
    ple_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_mode     (i_req.mode),
        .i_position (i_req.position),
        .i_stat     (w_stat),
        .i_count    (w_count),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    // Datapath: cell row, element count and the result register
    ple_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_idx   (w_idx),
        .i_value (i_req.value),
        .o_stat  (w_stat),
        .o_count (w_count),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule

[tb/sv/positional_list_engine_top_test.sv]
module positional_list_engine_top_test;
    import ple_pkg::*;

    // Mode 7 has no name in the package; the block must answer it as a no-op.
    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int         ITEM_GOAL   = 320;

    typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX} t_burst;

    // Shadow copy of the list: predicts every result of an accepted request and
    // checks the block's results against the expectations in arrival order.
    class list_scoreboard;
        logic [DATA_WIDTH_DEF-1:0] words[CAPACITY_DEF];
        int unsigned               word_count;
        t_res                      expected_results[$];
        int unsigned               errors;

        function void clear();
            word_count = 0;
            expected_results.delete();
            errors = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void push_result(logic [1:0] st, logic [31:0] val, logic fin);
            t_res e;
            e.status    = st;
            e.value_res = val;
            e.count     = word_count[4:0];
            e.last      = fin;
            expected_results.push_back(e);
        endfunction

        // Apply one accepted request to the shadow list and queue its results.
        function void note_request(t_req r);
            int          i;
            int          idx;
            logic [1:0]  st;
            st = ST_OK;
            case (r.mode)
                MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
                    // Full is refused ahead of any position check.
                    if (word_count >= CAPACITY_DEF) begin
                        st = ST_FULL;
                    end else begin
                        if (r.mode == MODE_INS_FRONT) idx = 0;
                        else if (r.mode == MODE_INS_BACK) idx = word_count;
                        else if (r.position < 1 || r.position > word_count + 1) idx = -1;
                        else idx = r.position - 1;
                        if (idx < 0) begin
                            st = ST_BADPOS;
                        end else begin
                            for (i = word_count; i > idx; i--) words[i] = words[i-1];
                            words[idx] = r.value;
                            word_count++;
                        end
                    end
                    push_result(st, '0, 1'b1);
                end
                MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
                    // Empty is refused ahead of any position check.
                    if (word_count == 0) begin
                        st = ST_EMPTY;
                    end else begin
                        if (r.mode == MODE_DEL_FRONT) idx = 0;
                        else if (r.mode == MODE_DEL_BACK) idx = word_count - 1;
                        else if (r.position < 1 || r.position > word_count) idx = -1;
                        else idx = r.position - 1;
                        if (idx < 0) begin
                            st = ST_BADPOS;
                        end else begin
                            for (i = idx; i + 1 < word_count; i++) words[i] = words[i+1];
                            word_count--;
                        end
                    end
                    push_result(st, '0, 1'b1);
                end
                MODE_DUMP: begin
                    if (word_count == 0) begin
                        push_result(ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (i = 0; i < word_count; i++)
                            push_result(ST_OK, words[i], i + 1 == word_count);
                    end
                end
                default: begin
                    push_result(ST_OK, '0, 1'b1);
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Compare one result with the oldest expectation, field by field.
        task check_result(t_res got);
            t_res e;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
            end else begin
                e = expected_results.pop_front();
                if (got.status !== e.status)
                    report_mismatch($sformatf("status %0d, want %0d", got.status, e.status));
                if (got.value_res !== e.value_res)
                    report_mismatch($sformatf("value_res %h, want %h",
                                              got.value_res, e.value_res));
                if (got.count !== e.count)
                    report_mismatch($sformatf("count %0d, want %0d", got.count, e.count));
                if (got.last !== e.last)
                    report_mismatch($sformatf("last %0d, want %0d", got.last, e.last));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_valid;
    t_res o_res;

    list_scoreboard sb;
    int unsigned    items_sent;
    bit             no_idle;

    positional_list_engine_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Take every strobed result; the block cannot be held off, so check it on
    // the edge that ends its cycle. Values read here are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            sb.check_result(o_res);
    end

    // Mostly back-to-back or short gaps, now and then a long one; a burst run
    // with no_idle set keeps start high the whole time.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Idle for a random gap, then present the request and hold it until the
    // edge where busy is low; that edge is the transfer.
    task automatic issue(t_req r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy === 1'b1);
        sb.note_request(r);
        items_sent++;
    endtask

    task automatic issue_fields(logic [2:0] mode, logic [31:0] value, logic [4:0] pos);
        t_req r;
        r.mode     = mode;
        r.value    = value;
        r.position = pos;
        issue(r);
    endtask

    // Pick a position: mostly inside the legal range for the current fill,
    // otherwise zero or anything the field can hold.
    function automatic logic [4:0] pick_position(bit for_insert);
        int r;
        int hi;
        r  = $urandom_range(0, 99);
        hi = for_insert ? sb.word_count + 1 : sb.word_count;
        if (hi < 1) hi = 1;
        if (hi > 31) hi = 31;
        if (r < 70) return 5'($urandom_range(1, hi));
        if (r < 85) return '0;
        return 5'($urandom_range(0, 31));
    endfunction

    // Build one random request, weighted by the kind of burst under way.
    function automatic t_req make_request(t_burst kind);
        t_req r;
        int   w;
        w = $urandom_range(0, 99);
        r.value = $urandom();
        case (kind)
            BURST_FILL: begin
                if (w < 30) r.mode = MODE_INS_FRONT;
                else if (w < 60) r.mode = MODE_INS_BACK;
                else if (w < 90) r.mode = MODE_INS_AT;
                else if (w < 95) r.mode = MODE_DUMP;
                else r.mode = (w & 1) ? MODE_DEL_AT : MODE_DEL_BACK;
            end
            BURST_DRAIN: begin
                if (w < 30) r.mode = MODE_DEL_FRONT;
                else if (w < 60) r.mode = MODE_DEL_BACK;
                else if (w < 90) r.mode = MODE_DEL_AT;
                else if (w < 95) r.mode = MODE_DUMP;
                else r.mode = (w & 1) ? MODE_INS_AT : MODE_INS_FRONT;
            end
            default: begin
                if (w < 3) r.mode = MODE_UNUSED;
                else r.mode = 3'($urandom_range(MODE_INS_FRONT, MODE_DUMP));
            end
        endcase
        r.position = pick_position(r.mode == MODE_INS_AT);
        return r;
    endfunction

    initial begin
        t_burst kind;
        int     extra;
        sb         = new();
        sb.clear();
        items_sent = 0;
        no_idle    = 1'b0;
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_req     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: refusals on an empty list come before any position check.
        issue_fields(MODE_DUMP, 32'h0, 5'd0);
        issue_fields(MODE_DEL_FRONT, 32'h0, 5'd0);
        issue_fields(MODE_DEL_BACK, 32'h0, 5'd0);
        issue_fields(MODE_DEL_AT, 32'h0, 5'd0);
        issue_fields(MODE_UNUSED, 32'hFFFF_FFFF, 5'd31);
        // Insert positions just outside the range, then at its edges.
        issue_fields(MODE_INS_AT, 32'h1234_5678, 5'd0);
        issue_fields(MODE_INS_AT, 32'h1234_5678, 5'd2);
        issue_fields(MODE_INS_AT, 32'h0000_0000, 5'd1);
        issue_fields(MODE_INS_FRONT, 32'hFFFF_FFFF, 5'd31);
        issue_fields(MODE_INS_BACK, 32'hA5A5_A5A5, 5'd0);
        issue_fields(MODE_INS_AT, 32'h5A5A_5A5A, 5'd4);
        issue_fields(MODE_INS_AT, 32'h8000_0001, 5'd2);
        // Delete positions outside the range, then the last and first one.
        issue_fields(MODE_DEL_AT, 32'h0, 5'd0);
        issue_fields(MODE_DEL_AT, 32'h0, 5'd6);
        issue_fields(MODE_DEL_AT, 32'hFFFF_FFFF, 5'd31);
        issue_fields(MODE_DEL_AT, 32'h0, 5'd5);
        issue_fields(MODE_DEL_AT, 32'h0, 5'd1);
        issue_fields(MODE_DUMP, 32'h0, 5'd0);
        issue_fields(MODE_UNUSED, 32'h0, 5'd0);

        // Random: fill bursts run the list up to full and then push against
        // it, drain bursts empty it and delete past the end, mixed bursts
        // wander. Every burst closes with a dump.
        while (items_sent < ITEM_GOAL) begin
            kind    = t_burst'($urandom_range(0, 2));
            no_idle = ($urandom_range(0, 3) == 0);
            case (kind)
                BURST_FILL: begin
                    while (sb.word_count < CAPACITY_DEF)
                        issue(make_request(BURST_FILL));
                    extra = $urandom_range(1, 3);
                    repeat (extra) issue(make_request(BURST_FILL));
                end
                BURST_DRAIN: begin
                    while (sb.word_count > 0)
                        issue(make_request(BURST_DRAIN));
                    extra = $urandom_range(1, 3);
                    repeat (extra) issue(make_request(BURST_DRAIN));
                end
                default: begin
                    repeat (20) issue(make_request(BURST_MIX));
                end
            endcase
            issue_fields(MODE_DUMP, $urandom(), 5'($urandom_range(0, 31)));
        end
        start <= 1'b0;

        // Drain: wait for every expected result, then keep the clock running so
        // that anything extra can show up.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (CAPACITY_DEF + 4) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("positional_list_engine_top_test OK");
        end else begin
            $display("positional_list_engine_top_test NOT OK");
        end
        $finish;
    end

    // Watchdog: far above the slowest legal run.
    initial begin
        #2_000_000;
        $display("positional_list_engine_top_test NOT OK");
        $finish;
    end

endmodule

[positional_list_engine_top.f]
hdl/ple_pkg.sv
hdl/ple_ctrl.sv
hdl/ple_dpath.sv
hdl/positional_list_engine_top.sv
tb/sv/positional_list_engine_top_test.sv
